[rtl/lpd_pkg.sv]
// shared types and codes for the length prefix deframer
// no dependencies
package lpd_pkg;

  localparam int unsigned CHANNELS      = 256;
  localparam int unsigned CHAN_W        = 8;
  localparam logic [31:0] HARD_LIMIT_RST = 32'h0800_0000;
  localparam logic [31:0] PREFIX_LEN    = 32'd4;
  localparam logic [31:0] MIN_REQUEST   = 32'd16;

  // command codes
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // byte_kind codes
  localparam logic [1:0] KIND_PREFIX = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_LEN_SHORT = 3'd1;
  localparam logic [2:0] ST_LEN_LIMIT = 3'd2;
  localparam logic [2:0] ST_REQ_SHORT = 3'd3;
  localparam logic [2:0] ST_DISCARD   = 3'd4;

  typedef struct packed {
    logic       command;
    logic [7:0] channel;
    logic [7:0] data_byte;
    logic       chunk_last;
  } lpd_in_t;

  typedef struct packed {
    logic [7:0] out_channel;
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       frame_last;
    logic       is_response;
    logic [2:0] status;
  } lpd_out_t;

  // per-channel reassembly entry
  typedef struct packed {
    logic [2:0]  prefix_count;
    logic [31:0] frame_length;
    logic [31:0] received_count;
    logic        response_flag;
  } lpd_entry_t;

endpackage

[rtl/length_prefix_deframer.sv]
// length prefix deframer top level: per-channel reassembly state in one memory
// depends on lpd_pkg
//
// Takes one request per accepted input (a data byte or a clear command, tagged
// with a channel) and returns exactly one result request for it, in order. The
// per-channel reassembly state (prefix byte count, assembled body length, body
// byte count, response flag) lives in a 256-entry synchronous memory with a
// registered read; a row of valid bits makes every entry read as zero after
// reset, so no clearing pass is needed and the block takes input right out of
// reset. Each request has two steps: the state memory read in the cycle of
// acceptance (S_IDLE), then the update, write-back and loading of the result
// register in S_READ; a stalled result register holds the update cycle until
// the result slot frees. in_stall is high for that update cycle. hard_limit is
// written through cfg_wr_en / cfg_wr_data and resets to 128 MiB; write it only
// while the block is idle.
module length_prefix_deframer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lpd_pkg::lpd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lpd_pkg::lpd_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t              state_r;
  lpd_pkg::lpd_in_t    item_r;
  lpd_pkg::lpd_out_t   out_data_r;
  lpd_pkg::lpd_out_t   out_data_nxt;
  logic                out_valid_r;
  logic                discard_r;
  logic                discard_nxt;
  logic [31:0]         hard_limit_r;

  // state memory and its valid row
  lpd_pkg::lpd_entry_t state_mem [lpd_pkg::CHANNELS];
  logic [lpd_pkg::CHANNELS-1:0] vld_r;
  lpd_pkg::lpd_entry_t rd_data_r;
  logic                rd_vld_r;

  lpd_pkg::lpd_entry_t cur;
  lpd_pkg::lpd_entry_t entry_nxt;

  logic                in_acc;
  logic                commit;
  logic                err;
  logic [31:0]         fl_new;
  logic [31:0]         rc_inc;
  logic [2:0]          pc_inc;
  logic                rf_new;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  // update cycle goes ahead only when the result slot is free
  assign commit    = (state_r == S_READ) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // never-written entries read as the reset value
  assign cur = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    entry_nxt   = cur;
    discard_nxt = discard_r;
    err         = 1'b0;
    fl_new      = cur.frame_length
                  | ({24'd0, item_r.data_byte} << {cur.prefix_count[1:0], 3'd0});
    pc_inc      = cur.prefix_count + 3'd1;
    rc_inc      = cur.received_count + 32'd1;
    rf_new      = (cur.received_count == 32'd3) ? item_r.data_byte[7] : cur.response_flag;

    out_data_nxt.out_channel = item_r.channel;
    out_data_nxt.out_byte    = 8'd0;
    out_data_nxt.byte_kind   = lpd_pkg::KIND_NONE;
    out_data_nxt.frame_last  = 1'b0;
    out_data_nxt.is_response = 1'b0;
    out_data_nxt.status      = lpd_pkg::ST_OK;

    if (item_r.command == lpd_pkg::CMD_CLEAR) begin
      entry_nxt = '0;
    end else if (discard_r) begin
      // dropping the rest of a chunk after an error, whatever the channel
      out_data_nxt.status = lpd_pkg::ST_DISCARD;
      if (item_r.chunk_last) begin
        discard_nxt = 1'b0;
      end
    end else if (cur.prefix_count < 3'd4) begin
      // length prefix byte, little-endian
      out_data_nxt.byte_kind = lpd_pkg::KIND_PREFIX;
      out_data_nxt.out_byte  = item_r.data_byte;
      entry_nxt.frame_length = fl_new;
      entry_nxt.prefix_count = pc_inc;
      if (pc_inc == 3'd4) begin
        if (fl_new < lpd_pkg::PREFIX_LEN) begin
          out_data_nxt.status = lpd_pkg::ST_LEN_SHORT;
          err = 1'b1;
        end else if (fl_new > hard_limit_r) begin
          out_data_nxt.status = lpd_pkg::ST_LEN_LIMIT;
          err = 1'b1;
        end else begin
          entry_nxt.received_count = 32'd0;
        end
      end
    end else begin
      // body byte; bit 7 of body byte 3 is bit 31 of the session word
      out_data_nxt.byte_kind   = lpd_pkg::KIND_BODY;
      out_data_nxt.out_byte    = item_r.data_byte;
      entry_nxt.response_flag  = rf_new;
      entry_nxt.received_count = rc_inc;
      if (rc_inc >= cur.frame_length) begin
        out_data_nxt.frame_last = 1'b1;
        if (!rf_new && (cur.frame_length < lpd_pkg::MIN_REQUEST)) begin
          out_data_nxt.status = lpd_pkg::ST_REQ_SHORT;
          err = 1'b1;
        end else begin
          out_data_nxt.is_response = rf_new;
        end
        entry_nxt = '0;
      end
    end

    if (err) begin
      entry_nxt = '0;
      if (!item_r.chunk_last) begin
        discard_nxt = 1'b1;
      end
    end
  end

  // control state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      discard_r    <= 1'b0;
      hard_limit_r <= lpd_pkg::HARD_LIMIT_RST;
    end else begin
      if (cfg_wr_en) begin
        hard_limit_r <= cfg_wr_data;
      end
      // a new result takes the slot even as the old one leaves
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (commit) begin
            state_r   <= S_IDLE;
            discard_r <= discard_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  // state memory: read at acceptance, written back in the update cycle;
  // the interlock on in_stall keeps the two from touching the same entry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= state_mem[in_data.channel];
    end
    if (commit) begin
      state_mem[item_r.channel] <= entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_vld_r <= vld_r[in_data.channel];
      end
      if (commit) begin
        vld_r[item_r.channel] <= 1'b1;
      end
    end
  end

  // an accepted request always moves to the update cycle
  a_acc_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_READ))
    else $error("accepted request did not reach the update cycle");

  // a new result appears only out of an update cycle
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(commit))
    else $error("result loaded without an update cycle");

  // discard mode starts only on an error byte that did not end its chunk
  a_discard_start: assert property (@(posedge clk) disable iff (!rst_n)
    (discard_r && !$past(discard_r)) |-> $past(commit && err && !item_r.chunk_last))
    else $error("discard started without an error");

  // results never carry the unused kind code
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.byte_kind == lpd_pkg::KIND_PREFIX ||
                     out_data_r.byte_kind == lpd_pkg::KIND_BODY ||
                     out_data_r.byte_kind == lpd_pkg::KIND_NONE))
    else $error("illegal byte_kind on result");

endmodule
